// ===== rtl/lfu_cache_table_macros.svh =====
// Assertion macros shared by the cache controller and datapath.
// Included by the RTL files that carry concurrent assertions; no other dependencies.
`ifndef LFU_CACHE_TABLE_MACROS_SVH
`define LFU_CACHE_TABLE_MACROS_SVH

`ifndef SYNTHESIS

// Checked at every edge once reset has been released.
`define LFU_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("lfu_cache_table: assertion failed");

// Checked at every edge, reset included.
`define LFU_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("lfu_cache_table: assertion failed");

`else

`define LFU_ASSERT(lbl, clk, rstn, prop)
`define LFU_ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

// ===== rtl/lfu_pkg.sv =====
// Shared constants, entry layout and controller/datapath interface types.
// Used by lfu_ctrl, lfu_dpath and lfu_cache_table; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package lfu_pkg;

    // Table geometry.
    localparam int ENTRIES = 16;
    localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int FILL_W  = $clog2(ENTRIES + 1);

    // Field widths.
    localparam int KEY_W   = 32;
    localparam int VAL_W   = 32;
    localparam int COUNT_W = 16;
    localparam int STAMP_W = 32;
    localparam int CAP_W   = 5;

    localparam logic [COUNT_W-1:0] COUNT_MAX  = '1;
    localparam logic [VAL_W-1:0]   READ_MISS  = '1;
    localparam logic [CAP_W-1:0]   CAP_RESET  = CAP_W'(16);

    // Operation codes carried in the input tuser.
    localparam logic OP_GET = 1'b0;
    localparam logic OP_SET = 1'b1;

    // Configuration register map (word index).
    localparam int  PADDR_W      = 3;
    localparam logic REG_CAPACITY = 1'b0;

    // One stored cache entry.
    typedef struct packed {
        logic [KEY_W-1:0]   key;
        logic [VAL_W-1:0]   value;
        logic [COUNT_W-1:0] count;
        logic [STAMP_W-1:0] stamp;
    } entry_t;

    // Controller to datapath.
    typedef struct packed {
        logic load;     // latch a new input word and restart the scan
        logic scan;     // read the slot at the scan pointer
        logic commit;   // write back and load the result register
    } cmd_t;

    // Datapath to controller.
    typedef struct packed {
        logic cap_zero;   // cache disabled
        logic fill_empty; // no filled slots to scan
        logic scan_last;  // scan pointer is at the last filled slot
        logic out_free;   // result register can take a new word
    } stat_t;

endpackage

`default_nettype wire

// ===== rtl/lfu_ctrl.sv =====
// Sequencer for the cache: accept, scan filled slots, drain, commit.
// Depends on lfu_pkg and lfu_cache_table_macros.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "lfu_cache_table_macros.svh"

module lfu_ctrl (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_tvalid,
    output logic               s_tready,
    input  lfu_pkg::stat_t     stat,
    output lfu_pkg::cmd_t      cmd
);
    import lfu_pkg::*;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_DRAIN  = 2'd2;
    localparam logic [1:0] ST_COMMIT = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    // One word in flight at a time; a new one is taken only when idle.
    assign s_tready   = (state_reg == ST_IDLE);
    assign cmd.load   = s_tvalid && s_tready;
    assign cmd.scan   = (state_reg == ST_SCAN);
    assign cmd.commit = (state_reg == ST_COMMIT) && stat.out_free;

    // Next-state logic.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (cmd.load) begin
                    if (stat.cap_zero || stat.fill_empty) begin
                        state_next = ST_COMMIT;
                    end else begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                if (stat.scan_last) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                state_next = ST_COMMIT;
            end
            ST_COMMIT: begin
                if (stat.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    `LFU_ASSERT(a_scan_has_slots, aclk, aresetn, (state_reg == ST_SCAN) |-> !stat.fill_empty)
    `LFU_ASSERT(a_commit_then_idle, aclk, aresetn, cmd.commit |=> s_tready)

endmodule

`default_nettype wire

// ===== rtl/lfu_dpath.sv =====
// Entry store, scan comparators, replacement decision and result register.
// Depends on lfu_pkg and lfu_cache_table_macros.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "lfu_cache_table_macros.svh"

module lfu_dpath (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  lfu_pkg::cmd_t                    cmd,
    output lfu_pkg::stat_t                   stat,
    input  wire logic [lfu_pkg::CAP_W-1:0]   capacity,
    input  wire logic                        in_opcode,
    input  wire logic [lfu_pkg::KEY_W-1:0]   in_key,
    input  wire logic [lfu_pkg::VAL_W-1:0]   in_value,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic                             out_hit,
    output logic [lfu_pkg::VAL_W-1:0]        out_read_value,
    output logic                             out_evicted,
    output logic [lfu_pkg::KEY_W-1:0]        out_evicted_key
);
    import lfu_pkg::*;

    // Entry memory: no reset, only slots below the fill count are used.
    entry_t entry_mem [ENTRIES];
    entry_t rd_data_reg;

    // Latched request.
    logic             op_reg;
    logic [KEY_W-1:0] key_reg;
    logic [VAL_W-1:0] val_reg;

    // Table-wide state.
    logic [FILL_W-1:0]  filled_reg;
    logic [FILL_W-1:0]  filled_next;
    logic [STAMP_W-1:0] stamp_reg;
    logic [STAMP_W-1:0] stamp_next;

    // Scan pointer and compare stage.
    logic [IDX_W-1:0] scan_idx_reg;
    logic             cmp_valid_reg;
    logic [IDX_W-1:0] cmp_idx_reg;

    // Match and victim trackers.
    logic               found_reg;
    logic [IDX_W-1:0]   match_idx_reg;
    logic [VAL_W-1:0]   match_val_reg;
    logic [COUNT_W-1:0] match_count_reg;
    logic [IDX_W-1:0]   best_idx_reg;
    logic [KEY_W-1:0]   best_key_reg;
    logic [COUNT_W-1:0] best_count_reg;
    logic [STAMP_W-1:0] best_stamp_reg;

    // Result register.
    logic             out_valid_reg;
    logic             out_hit_reg;
    logic [VAL_W-1:0] out_read_reg;
    logic             out_evicted_reg;
    logic [KEY_W-1:0] out_evk_reg;

    // Commit decision.
    logic [FILL_W-1:0]  cap_eff;
    logic               wr_en;
    logic [IDX_W-1:0]   wr_idx;
    entry_t             wr_entry;
    logic               res_hit;
    logic [VAL_W-1:0]   res_read;
    logic               res_evicted;
    logic [KEY_W-1:0]   res_evk;
    logic [COUNT_W-1:0] match_count_inc;
    logic               victim_better;

    // Capacities above the table size act as the table size.
    assign cap_eff = (32'(capacity) > ENTRIES) ? FILL_W'(ENTRIES) : FILL_W'(capacity);

    assign stat.cap_zero   = (cap_eff == '0);
    assign stat.fill_empty = (filled_reg == '0);
    assign stat.scan_last  = ((FILL_W'(scan_idx_reg) + FILL_W'(1)) == filled_reg);
    assign stat.out_free   = !out_valid_reg || out_ready;

    assign match_count_inc = (match_count_reg == COUNT_MAX) ? match_count_reg
                                                            : match_count_reg + COUNT_W'(1);

    // Lower count wins; on equal counts the older stamp wins; slot 0 seeds the search.
    assign victim_better = (cmp_idx_reg == '0)
                        || (rd_data_reg.count < best_count_reg)
                        || ((rd_data_reg.count == best_count_reg)
                            && (rd_data_reg.stamp < best_stamp_reg));

    // Decide the write-back and the result word from the finished scan.
    always_comb begin
        wr_en       = 1'b0;
        wr_idx      = match_idx_reg;
        wr_entry    = '{key: key_reg, value: val_reg, count: COUNT_W'(1),
                        stamp: stamp_reg + STAMP_W'(1)};
        res_hit     = 1'b0;
        res_read    = '0;
        res_evicted = 1'b0;
        res_evk     = '0;
        filled_next = filled_reg;
        stamp_next  = stamp_reg;
        if (cap_eff == '0) begin
            // Disabled: nothing changes, a get reports a miss.
            res_read = (op_reg == OP_GET) ? READ_MISS : '0;
        end else if (op_reg == OP_GET) begin
            if (found_reg) begin
                res_hit        = 1'b1;
                res_read       = match_val_reg;
                stamp_next     = stamp_reg + STAMP_W'(1);
                wr_en          = 1'b1;
                wr_entry.value = match_val_reg;
                wr_entry.count = match_count_inc;
            end else begin
                res_read = READ_MISS;
            end
        end else begin
            stamp_next = stamp_reg + STAMP_W'(1);
            wr_en      = 1'b1;
            if (found_reg) begin
                res_hit        = 1'b1;
                wr_entry.count = match_count_inc;
            end else if (filled_reg < cap_eff) begin
                wr_idx      = filled_reg[IDX_W-1:0];
                filled_next = filled_reg + FILL_W'(1);
            end else begin
                wr_idx      = best_idx_reg;
                res_evicted = 1'b1;
                res_evk     = best_key_reg;
            end
        end
    end

    // Entry memory write port.
    always_ff @(posedge aclk) begin
        if (cmd.commit && wr_en) begin
            entry_mem[wr_idx] <= wr_entry;
        end
    end

    // Entry memory read port, registered.
    always_ff @(posedge aclk) begin
        rd_data_reg <= entry_mem[scan_idx_reg];
    end

    // Request latch and scan pointer.
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg       <= in_opcode;
            key_reg      <= in_key;
            val_reg      <= in_value;
            scan_idx_reg <= '0;
        end else if (cmd.scan) begin
            scan_idx_reg <= scan_idx_reg + IDX_W'(1);
        end
        cmp_idx_reg <= scan_idx_reg;
    end

    // Match and victim tracking over the scanned slots.
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            found_reg <= 1'b0;
        end else if (cmp_valid_reg) begin
            if (!found_reg && (rd_data_reg.key == key_reg)) begin
                found_reg       <= 1'b1;
                match_idx_reg   <= cmp_idx_reg;
                match_val_reg   <= rd_data_reg.value;
                match_count_reg <= rd_data_reg.count;
            end
            if (victim_better) begin
                best_idx_reg   <= cmp_idx_reg;
                best_key_reg   <= rd_data_reg.key;
                best_count_reg <= rd_data_reg.count;
                best_stamp_reg <= rd_data_reg.stamp;
            end
        end
    end

    // Control state: fill count, stamp, compare valid and result valid.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            filled_reg    <= '0;
            stamp_reg     <= '0;
            cmp_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            cmp_valid_reg <= cmd.scan;
            if (cmd.commit) begin
                filled_reg    <= filled_next;
                stamp_reg     <= stamp_next;
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Result word payload.
    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            out_hit_reg     <= res_hit;
            out_read_reg    <= res_read;
            out_evicted_reg <= res_evicted;
            out_evk_reg     <= res_evk;
        end
    end

    assign out_valid       = out_valid_reg;
    assign out_hit         = out_hit_reg;
    assign out_read_value  = out_read_reg;
    assign out_evicted     = out_evicted_reg;
    assign out_evicted_key = out_evk_reg;

    `LFU_ASSERT(a_fill_bounded, aclk, aresetn, 32'(filled_reg) <= ENTRIES)
    `LFU_ASSERT(a_cmp_in_fill, aclk, aresetn, cmp_valid_reg |-> (FILL_W'(cmp_idx_reg) < filled_reg))
    `LFU_ASSERT(a_evict_not_hit, aclk, aresetn, (out_valid_reg && out_evicted_reg) |-> !out_hit_reg)

endmodule

`default_nettype wire

// ===== rtl/lfu_cache_table.sv =====
// Top level of the LFU key-value cache: stream ports, APB register and sub-blocks.
// Depends on lfu_pkg, lfu_ctrl and lfu_dpath.
//
//  Channel  Dir  Handshake                 Contents
//  s_       in   s_tvalid / s_tready       tdata {write_value, lookup_key}, tuser opcode
//  m_       out  m_tvalid / m_tready       tdata {evicted_key, read_value}, tuser {evicted, hit}
//  APB      in   psel / penable / pready   capacity_in_use at byte address 0
//
// Each word passes from its acceptance to the next acceptance through an idle state that accepts
// it, a scan step for each filled slot over the single entry memory read port, a drain of the
// registered read and a commit that loads the result register; with no filled slots or with
// the cache disabled the scan and drain are skipped.
// Reset (aresetn low, synchronous) empties the table, zeroes the stamp and sets capacity 16.
// A full result register stalls only the commit; the next word is taken once that word
// has committed.
`timescale 1ns / 1ps
`default_nettype none

module lfu_cache_table (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    // Input stream.
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [63:0]                   s_tdata,  // [31:0] lookup_key, [63:32] write_value
    input  wire logic [0:0]                    s_tuser,  // [0] opcode
    // Result stream.
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [63:0]                        m_tdata,  // [31:0] read_value, [63:32] evicted_key
    output logic [1:0]                         m_tuser,  // [0] hit, [1] evicted
    // Configuration port.
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [lfu_pkg::PADDR_W-1:0]   paddr,
    input  wire logic [31:0]                   pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready
);
    import lfu_pkg::*;

    logic [CAP_W-1:0] capacity_reg;
    logic             cfg_write;
    cmd_t             cmd;
    stat_t            stat;
    logic             out_hit;
    logic             out_evicted;
    logic [VAL_W-1:0] out_read_value;
    logic [KEY_W-1:0] out_evicted_key;

    // Register access; the word index sits above the byte offset.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready && (paddr[2] == REG_CAPACITY);
    assign prdata    = (paddr[2] == REG_CAPACITY) ? 32'(capacity_reg) : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            capacity_reg <= CAP_RESET;
        end else if (cfg_write) begin
            capacity_reg <= pwdata[CAP_W-1:0];
        end
    end

    // Sequencer.
    lfu_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Storage, scan and result register.
    lfu_dpath u_dpath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .stat            (stat),
        .capacity        (capacity_reg),
        .in_opcode       (s_tuser[0]),
        .in_key          (s_tdata[KEY_W-1:0]),
        .in_value        (s_tdata[KEY_W+VAL_W-1:KEY_W]),
        .out_valid       (m_tvalid),
        .out_ready       (m_tready),
        .out_hit         (out_hit),
        .out_read_value  (out_read_value),
        .out_evicted     (out_evicted),
        .out_evicted_key (out_evicted_key)
    );

    // Result word packing.
    assign m_tdata = {out_evicted_key, out_read_value};
    assign m_tuser = {out_evicted, out_hit};

endmodule

`default_nettype wire
